[rtl/capdu_pkg.sv]
`default_nettype none

package capdu_pkg;

	localparam int unsigned HDR_BYTES  = 7;
	localparam int unsigned CNT_W      = 17;
	localparam int unsigned LC_W       = 16;
	localparam int unsigned LE_W       = 17;
	localparam int unsigned OFF_W      = 3;
	localparam int unsigned TDATA_W    = 88;

	localparam logic [CNT_W-1:0] COUNT_MAX    = '1;
	localparam logic [CNT_W-1:0] MIN_FRAME    = 17'd4;
	localparam logic [CNT_W-1:0] LEN_LE_ONLY  = 17'd5;
	localparam logic [CNT_W-1:0] LEN_EXT_LE   = 17'd7;
	localparam logic [CNT_W-1:0] LEN_EXT_MIN  = 17'd8;
	localparam logic [CNT_W-1:0] SHORT_NO_LE  = 17'd5;
	localparam logic [CNT_W-1:0] SHORT_WITH_LE = 17'd6;
	localparam logic [CNT_W-1:0] EXT_NO_LE    = 17'd7;
	localparam logic [CNT_W-1:0] EXT_WITH_LE  = 17'd9;
	localparam logic [LE_W-1:0]  SHORT_LE_MAX = 17'd256;
	localparam logic [LE_W-1:0]  EXT_LE_MAX   = 17'd65536;

	localparam logic [OFF_W-1:0] OFF_NONE  = 3'd0;
	localparam logic [OFF_W-1:0] OFF_SHORT = 3'd5;
	localparam logic [OFF_W-1:0] OFF_EXT   = 3'd7;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	// Frame snapshot handed from the byte tracker to the decoder
	typedef struct packed {
		logic [HDR_BYTES-1:0][7:0] hdr;
		logic [7:0]                prev_byte;
		logic [7:0]                last_byte;
		logic [CNT_W-1:0]          frame_len;
	} frame_snap_t;

	// Decoded descriptor
	typedef struct packed {
		logic             status;
		logic [7:0]       class_byte;
		logic [7:0]       instruction_byte;
		logic [7:0]       param_one;
		logic [7:0]       param_two;
		logic             extended_flag;
		logic [LC_W-1:0]  command_data_length;
		logic [LE_W-1:0]  expected_length;
		logic [OFF_W-1:0] data_offset;
		logic [CNT_W-1:0] frame_length;
	} apdu_desc_t;

endpackage

`default_nettype wire

[rtl/capdu_frame_track.sv]
`default_nettype none

module capdu_frame_track import capdu_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        byte_last,
	output logic             snap_valid,
	input  wire logic        snap_ready,
	output frame_snap_t      snap
);

	logic [CNT_W-1:0]          count_q;
	logic [7:0]                cur_q;
	logic [HDR_BYTES-1:0][7:0] hdr_q;
	logic                      snap_valid_s1;
	frame_snap_t               snap_s1;

	logic             acc;
	logic [CNT_W-1:0] count_inc;
	frame_snap_t      snap_d;

	assign in_ready  = !snap_valid_s1 || snap_ready;
	assign acc       = in_valid && in_ready;
	assign count_inc = (count_q == COUNT_MAX) ? COUNT_MAX : count_q + 1'b1;

	// Snapshot sees the incoming byte in its header slot
	always_comb begin
		for (int i = 0; i < HDR_BYTES; i++) begin
			snap_d.hdr[i] = (count_q == CNT_W'(i)) ? data_byte : hdr_q[i];
		end
		snap_d.prev_byte = cur_q;
		snap_d.last_byte = data_byte;
		snap_d.frame_len = count_inc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			cur_q         <= '0;
			snap_valid_s1 <= 1'b0;
		end else begin
			if (acc && byte_last) begin
				snap_valid_s1 <= 1'b1;
			end else if (snap_ready) begin
				snap_valid_s1 <= 1'b0;
			end
			if (acc) begin
				if (byte_last) begin
					count_q <= '0;
					cur_q   <= '0;
				end else begin
					count_q <= count_inc;
					cur_q   <= data_byte;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && count_q < CNT_W'(HDR_BYTES)) hdr_q[count_q[2:0]] <= data_byte;
		if (acc && byte_last) snap_s1 <= snap_d;
	end

	assign snap_valid = snap_valid_s1;
	assign snap       = snap_s1;

endmodule

`default_nettype wire

[rtl/capdu_decode.sv]
`default_nettype none

module capdu_decode import capdu_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        snap_valid,
	output logic             snap_ready,
	input  frame_snap_t      snap,
	output logic             out_valid,
	input  wire logic        out_ready,
	output apdu_desc_t       out_desc
);

	logic       out_valid_s2;
	apdu_desc_t out_desc_s2;
	apdu_desc_t desc_d;

	logic [7:0]       b4;
	logic [15:0]      hdr_word;
	logic [15:0]      tail_word;
	logic [CNT_W-1:0] n;
	logic             err;
	logic             ext;
	logic [LC_W-1:0]  lc;
	logic [LE_W-1:0]  le;
	logic [OFF_W-1:0] off;

	assign b4        = snap.hdr[4];
	assign hdr_word  = {snap.hdr[5], snap.hdr[6]};
	assign tail_word = {snap.prev_byte, snap.last_byte};
	assign n         = snap.frame_len;

	// Pick the layout from length and byte 4
	always_comb begin
		err = 1'b0;
		ext = 1'b0;
		lc  = '0;
		le  = '0;
		off = OFF_NONE;
		if (n < MIN_FRAME) begin
			err = 1'b1;
		end else if (n == MIN_FRAME) begin
			err = 1'b0;
		end else if (n == LEN_LE_ONLY) begin
			le = (b4 != 8'h00) ? LE_W'(b4) : SHORT_LE_MAX;
		end else if (b4 != 8'h00) begin
			lc  = LC_W'(b4);
			off = OFF_SHORT;
			if (n == CNT_W'(b4) + SHORT_WITH_LE) begin
				le = (snap.last_byte != 8'h00) ? LE_W'(snap.last_byte) : SHORT_LE_MAX;
			end else if (n != CNT_W'(b4) + SHORT_NO_LE) begin
				err = 1'b1;
			end
		end else if (n == LEN_EXT_LE) begin
			ext = 1'b1;
			le  = (hdr_word != 16'h0000) ? LE_W'(hdr_word) : EXT_LE_MAX;
		end else if (n >= LEN_EXT_MIN) begin
			ext = 1'b1;
			lc  = hdr_word;
			off = OFF_EXT;
			if (n == CNT_W'(hdr_word) + EXT_WITH_LE) begin
				le = (tail_word != 16'h0000) ? LE_W'(tail_word) : EXT_LE_MAX;
			end else if (n != CNT_W'(hdr_word) + EXT_NO_LE) begin
				err = 1'b1;
			end
		end else begin
			err = 1'b1;
		end

		desc_d = '0;
		desc_d.frame_length = n;
		if (err) begin
			desc_d.status = STATUS_ERR;
		end else begin
			desc_d.status              = STATUS_OK;
			desc_d.class_byte          = snap.hdr[0];
			desc_d.instruction_byte    = snap.hdr[1];
			desc_d.param_one           = snap.hdr[2];
			desc_d.param_two           = snap.hdr[3];
			desc_d.extended_flag       = ext;
			desc_d.command_data_length = lc;
			desc_d.expected_length     = le;
			desc_d.data_offset         = off;
		end
	end

	assign snap_ready = !out_valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (snap_ready) begin
			out_valid_s2 <= snap_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_ready && snap_valid) out_desc_s2 <= desc_d;
	end

	assign out_valid = out_valid_s2;
	assign out_desc  = out_desc_s2;

endmodule

`default_nettype wire

[rtl/command_apdu_header_parser.sv]
`default_nettype none

// Command APDU header parser. Bytes of one command APDU stream in on the s_
// side, one item per byte, with s_tlast on the final byte. The block keeps the
// first seven bytes, the last two bytes and a byte count that saturates at
// 131071; when the flagged byte is taken it emits one descriptor on the m_
// side, and nothing for any other byte. The descriptor carries CLA, INS, P1,
// P2, the extended-length flag, Lc, Le (an encoded zero Le reads as 256 short
// or 65536 extended, 0 when no Le is present), the data offset (5 short, 7
// extended, 0 none) and the frame length. A frame under four bytes, or one
// whose length fits neither the short nor the extended layout, gives status
// 1 in m_tuser with every descriptor field zero but the frame length. One byte
// is taken every cycle unless a snapshot is held stalled; the descriptor
// passes through the snapshot register and then the output register, and a
// stalled output holds only the snapshot stage, so bytes of the next frame
// keep flowing until a second descriptor is waiting. No clearing pass follows reset.
module command_apdu_header_parser import capdu_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [7:0]          s_tdata,   // [7:0] data_byte
	input  wire logic                s_tlast,   // byte_last
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// [7:0] class_byte, [15:8] instruction_byte, [23:16] param_one,
	// [31:24] param_two, [32] extended_flag, [48:33] command_data_length,
	// [65:49] expected_length, [68:66] data_offset, [85:69] frame_length,
	// [87:86] zero
	output logic [TDATA_W-1:0]       m_tdata,
	output logic                     m_tuser    // [0] status
);

	logic        snap_valid;
	logic        snap_ready;
	frame_snap_t snap;
	apdu_desc_t  desc;

	// Track the frame and freeze it on the flagged byte
	capdu_frame_track u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.data_byte  (s_tdata),
		.byte_last  (s_tlast),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap       (snap)
	);

	// Classify the layout and hold the descriptor until taken
	capdu_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap       (snap),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_desc   (desc)
	);

	// Pack the descriptor, first field lowest
	assign m_tdata = {2'b00,
		desc.frame_length,
		desc.data_offset,
		desc.expected_length,
		desc.command_data_length,
		desc.extended_flag,
		desc.param_two,
		desc.param_one,
		desc.instruction_byte,
		desc.class_byte};
	assign m_tuser = desc.status;

endmodule

`default_nettype wire

[rtl/capdu_checker.sv]
`default_nettype none

module capdu_checker import capdu_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               s_tvalid,
	input wire logic               s_tready,
	input wire logic               s_tlast,
	input wire logic               m_tvalid,
	input wire logic               m_tready,
	input wire logic [TDATA_W-1:0] m_tdata,
	input wire logic               m_tuser
);

	// Hold a stalled descriptor
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("descriptor changed while stalled");

	// Error descriptors carry only the frame length
	a_err_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[68:0] == 69'd0)
		else $error("error descriptor has non-zero fields");

	// A good descriptor needs a full header
	a_ok_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[85:69] >= MIN_FRAME)
		else $error("good descriptor from short frame");

	// Offset follows the length layout
	a_offset: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |->
			(m_tdata[68:66] == OFF_NONE) ||
			(m_tdata[68:66] == OFF_SHORT && !m_tdata[32]) ||
			(m_tdata[68:66] == OFF_EXT && m_tdata[32]))
		else $error("data offset does not match layout");

	// A descriptor appears only after a flagged byte was taken
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
		else $error("descriptor without a flagged byte");

endmodule

bind command_apdu_header_parser capdu_checker u_capdu_checker (.*);

`default_nettype wire
